FILE: design/cdsu_pkg.sv
package cdsu_pkg;

    // op codes
    localparam logic [2:0] OP_NEXT_DAY   = 3'd0;
    localparam logic [2:0] OP_PREV_DAY   = 3'd1;
    localparam logic [2:0] OP_NEXT_MONTH = 3'd2;
    localparam logic [2:0] OP_PREV_MONTH = 3'd3;
    localparam logic [2:0] OP_ADD_YEARS  = 3'd4;
    localparam logic [2:0] OP_SUB_YEARS  = 3'd5;

    localparam int YEAR_W  = 14;
    localparam int YEXT_W  = 15;   // holds year + amount before the range check
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_ONE   = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_DEC_END = 5'd31;

    // floor(x / 100) = (x * 10486) >> 20, exact for x < 2^15
    localparam logic [13:0] DIV100_MUL   = 14'd10486;
    localparam int          DIV100_SHIFT = 20;
    localparam logic [6:0]  HUNDRED      = 7'd100;

    typedef struct packed {
        logic [YEXT_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               date_valid;
        logic               range_err;
    } t_item;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic               leap;
        logic [DAY_W-1:0]   month_length;
        logic               date_valid;
        logic               range_err;
    } t_result;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                4'd2: len = leap ? 5'd29 : 5'd28;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // (31 * mm) / 12 with March as month one of the shifted year
    function automatic logic [5:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [5:0] off;
        begin
            case (m)
                4'd1:  off = 6'd28;
                4'd2:  off = 6'd31;
                4'd3:  off = 6'd2;
                4'd4:  off = 6'd5;
                4'd5:  off = 6'd7;
                4'd6:  off = 6'd10;
                4'd7:  off = 6'd12;
                4'd8:  off = 6'd15;
                4'd9:  off = 6'd18;
                4'd10: off = 6'd20;
                4'd11: off = 6'd23;
                4'd12: off = 6'd25;
                default: off = 6'd0;
            endcase
            return off;
        end
    endfunction

endpackage

FILE: design/cdsu_cal_back.sv
// Back half: leap year and month length of the result, weekday by
// Zeller-style sum and a folded mod 7. Three register stages.
module cdsu_cal_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  cdsu_pkg::t_item   i_item,
    output logic              o_vld,
    output cdsu_pkg::t_result o_res
);

    localparam int PROD_W = cdsu_pkg::YEXT_W + 14;
    localparam int Q_W    = PROD_W - cdsu_pkg::DIV100_SHIFT;
    localparam int SUM_W  = 16;

    // stage 4: products for year / 100
    logic                           r_s4_vld;
    cdsu_pkg::t_item                r_s4_item;
    logic [cdsu_pkg::YEXT_W-1:0]    r_s4_yy;
    logic [5:0]                     r_s4_moff;
    logic [PROD_W-1:0]              r_s4_prod_n;
    logic [PROD_W-1:0]              r_s4_prod_yy;
    logic [cdsu_pkg::YEXT_W-1:0]    n_s4_yy;

    // stage 5: leap, length, weekday sum
    logic                           r_s5_vld;
    cdsu_pkg::t_item                r_s5_item;
    logic                           r_s5_leap;
    logic [cdsu_pkg::DAY_W-1:0]     r_s5_mlen;
    logic [SUM_W-1:0]               r_s5_sum;

    logic [Q_W-1:0]                 q_n;
    logic [Q_W-1:0]                 q_yy;
    logic                           leap_n;
    logic [SUM_W-1:0]               n_s5_sum;

    // stage 6: mod 7 and output register
    logic                           r_s6_vld;
    cdsu_pkg::t_result              r_s6_res;
    logic [5:0]                     fold1;
    logic [3:0]                     fold2;
    logic [cdsu_pkg::WDAY_W-1:0]    wday;

    // January and February count in the previous year
    assign n_s4_yy = (i_item.month == cdsu_pkg::MONTH_JAN ||
                      i_item.month == cdsu_pkg::MONTH_FEB)
                   ? i_item.year - cdsu_pkg::YEXT_W'(1) : i_item.year;

    always_ff @(posedge i_clk) begin
        r_s4_item    <= i_item;
        r_s4_yy      <= n_s4_yy;
        r_s4_moff    <= cdsu_pkg::month_offset(i_item.month);
        r_s4_prod_n  <= PROD_W'(i_item.year) * PROD_W'(cdsu_pkg::DIV100_MUL);
        r_s4_prod_yy <= PROD_W'(n_s4_yy) * PROD_W'(cdsu_pkg::DIV100_MUL);
    end

    assign q_n  = r_s4_prod_n[PROD_W-1:cdsu_pkg::DIV100_SHIFT];
    assign q_yy = r_s4_prod_yy[PROD_W-1:cdsu_pkg::DIV100_SHIFT];

    // divisible by 400 <=> remainder by 100 is zero and quotient by 100 is a multiple of 4
    assign leap_n = (r_s4_item.year[1:0] == 2'b00) &&
                    ((r_s4_item.year != (cdsu_pkg::YEXT_W'(q_n) *
                                         cdsu_pkg::YEXT_W'(cdsu_pkg::HUNDRED))) ||
                     (q_n[1:0] == 2'b00));

    assign n_s5_sum = SUM_W'(r_s4_item.day) + SUM_W'(r_s4_yy) + SUM_W'(r_s4_yy >> 2)
                    - SUM_W'(q_yy) + SUM_W'(q_yy >> 2) + SUM_W'(r_s4_moff);

    always_ff @(posedge i_clk) begin
        r_s5_item <= r_s4_item;
        r_s5_leap <= leap_n;
        r_s5_mlen <= cdsu_pkg::month_len(r_s4_item.month, leap_n);
        r_s5_sum  <= n_s5_sum;
    end

    // 8 = 1 mod 7: add octal digits, twice, then one correction
    assign fold1 = 6'(r_s5_sum[2:0]) + 6'(r_s5_sum[5:3]) + 6'(r_s5_sum[8:6])
                 + 6'(r_s5_sum[11:9]) + 6'(r_s5_sum[14:12]) + 6'(r_s5_sum[15]);
    assign fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
    assign wday  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    always_ff @(posedge i_clk) begin
        r_s6_res.year         <= r_s5_item.year[cdsu_pkg::YEAR_W-1:0];
        r_s6_res.month        <= r_s5_item.month;
        r_s6_res.day          <= r_s5_item.day;
        r_s6_res.weekday      <= r_s5_item.date_valid ? wday : '0;
        r_s6_res.leap         <= r_s5_leap;
        r_s6_res.month_length <= r_s5_mlen;
        r_s6_res.date_valid   <= r_s5_item.date_valid;
        r_s6_res.range_err    <= r_s5_item.range_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else begin
            r_s4_vld <= i_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    assign o_vld = r_s6_vld;
    assign o_res = r_s6_res;

endmodule

FILE: design/calendar_date_step_unit.sv
// A beat taken on start passes the registers s1 through s6 and returns on o_done.
// Throughput: one beat per cycle, start may be held high every cycle.
// busy is always low; the result strobe cannot be held off by the receiver.
// Reset (synchronous, active low) clears the pipeline valid bits only;
// no memory, so there is no clearing pass and the block is ready at once.
module calendar_date_step_unit #(
    parameter int YEAR_MAX = 9999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [13:0] i_in_year,
    input  logic [3:0]  i_in_month,
    input  logic [4:0]  i_in_day,
    input  logic [13:0] i_year_amount,
    output logic        o_done,
    output logic [13:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [2:0]  o_weekday,
    output logic        o_leap_flag,
    output logic [4:0]  o_month_length,
    output logic        o_date_valid,
    output logic        o_range_error
);

    // Pipeline:
    //   s1  input register, in_year * reciprocal of 100
    //   s2  leap year of the input, month length, date check
    //   s3  the step itself, year range check, revert when the year is out of range
    //   s4..s6 in cdsu_cal_back: leap/length of the result, weekday

    localparam int          PROD_W = cdsu_pkg::YEAR_W + 14;
    localparam int          Q_W    = PROD_W - cdsu_pkg::DIV100_SHIFT;
    localparam logic [16:0] YMAX   = 17'(YEAR_MAX);

    logic                           accept;

    // stage 1
    logic                           r_s1_vld;
    logic [2:0]                     r_s1_op;
    logic [cdsu_pkg::YEAR_W-1:0]    r_s1_y;
    logic [cdsu_pkg::MONTH_W-1:0]   r_s1_m;
    logic [cdsu_pkg::DAY_W-1:0]     r_s1_d;
    logic [cdsu_pkg::YEAR_W-1:0]    r_s1_amt;
    logic [PROD_W-1:0]              r_s1_prod;

    // stage 2
    logic                           r_s2_vld;
    logic [2:0]                     r_s2_op;
    logic [cdsu_pkg::YEAR_W-1:0]    r_s2_y;
    logic [cdsu_pkg::MONTH_W-1:0]   r_s2_m;
    logic [cdsu_pkg::DAY_W-1:0]     r_s2_d;
    logic [cdsu_pkg::YEAR_W-1:0]    r_s2_amt;
    logic                           r_s2_leap;
    logic [cdsu_pkg::DAY_W-1:0]     r_s2_dim;
    logic                           r_s2_valid;

    logic [Q_W-1:0]                 q_y;
    logic                           leap_y;
    logic [cdsu_pkg::DAY_W-1:0]     dim_y;
    logic                           valid_y;

    // stage 3
    logic                           r_s3_vld;
    cdsu_pkg::t_item                r_s3_item;
    cdsu_pkg::t_item                n_s3_item;
    logic [cdsu_pkg::YEXT_W-1:0]    y_ext;
    logic [cdsu_pkg::DAY_W-1:0]     step_len;

    logic                           back_vld;
    cdsu_pkg::t_result              back_res;

    // every cycle is open for a new beat
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---- stage 1 ----
    always_ff @(posedge i_clk) begin
        r_s1_op   <= i_op;
        r_s1_y    <= i_in_year;
        r_s1_m    <= i_in_month;
        r_s1_d    <= i_in_day;
        r_s1_amt  <= i_year_amount;
        r_s1_prod <= PROD_W'(i_in_year) * PROD_W'(cdsu_pkg::DIV100_MUL);
    end

    // ---- stage 2: Gregorian leap rule via quotient by 100 ----
    assign q_y    = r_s1_prod[PROD_W-1:cdsu_pkg::DIV100_SHIFT];
    assign leap_y = (r_s1_y[1:0] == 2'b00) &&
                    ((r_s1_y != (cdsu_pkg::YEAR_W'(q_y) *
                                 cdsu_pkg::YEAR_W'(cdsu_pkg::HUNDRED))) ||
                     (q_y[1:0] == 2'b00));
    assign dim_y  = cdsu_pkg::month_len(r_s1_m, leap_y);

    // month_len is zero outside 1..12, so that case fails the day compare
    assign valid_y = (r_s1_y != '0) && (17'(r_s1_y) <= YMAX) &&
                     (r_s1_d != '0) && (r_s1_d <= dim_y);

    always_ff @(posedge i_clk) begin
        r_s2_op    <= r_s1_op;
        r_s2_y     <= r_s1_y;
        r_s2_m     <= r_s1_m;
        r_s2_d     <= r_s1_d;
        r_s2_amt   <= r_s1_amt;
        r_s2_leap  <= leap_y;
        r_s2_dim   <= dim_y;
        r_s2_valid <= valid_y;
    end

    // ---- stage 3: the step ----
    // A month step can only land on February without changing the year,
    // so the input year's leap flag serves the clamp.
    assign y_ext = cdsu_pkg::YEXT_W'(r_s2_y);

    always_comb begin
        n_s3_item.year       = y_ext;
        n_s3_item.month      = r_s2_m;
        n_s3_item.day        = r_s2_d;
        n_s3_item.date_valid = r_s2_valid;
        n_s3_item.range_err  = 1'b0;
        step_len             = '0;
        if (r_s2_valid) begin
            case (r_s2_op)
                cdsu_pkg::OP_NEXT_DAY: begin
                    if (r_s2_d == r_s2_dim) begin
                        n_s3_item.day = cdsu_pkg::DAY_ONE;
                        if (r_s2_m == cdsu_pkg::MONTH_DEC) begin
                            n_s3_item.month = cdsu_pkg::MONTH_JAN;
                            n_s3_item.year  = y_ext + cdsu_pkg::YEXT_W'(1);
                        end else begin
                            n_s3_item.month = r_s2_m + cdsu_pkg::MONTH_W'(1);
                        end
                    end else begin
                        n_s3_item.day = r_s2_d + cdsu_pkg::DAY_W'(1);
                    end
                end
                cdsu_pkg::OP_PREV_DAY: begin
                    if (r_s2_d == cdsu_pkg::DAY_ONE) begin
                        if (r_s2_m == cdsu_pkg::MONTH_JAN) begin
                            n_s3_item.year  = y_ext - cdsu_pkg::YEXT_W'(1);
                            n_s3_item.month = cdsu_pkg::MONTH_DEC;
                            n_s3_item.day   = cdsu_pkg::DAY_DEC_END;
                        end else begin
                            n_s3_item.month = r_s2_m - cdsu_pkg::MONTH_W'(1);
                            n_s3_item.day   = cdsu_pkg::month_len(
                                r_s2_m - cdsu_pkg::MONTH_W'(1), r_s2_leap);
                        end
                    end else begin
                        n_s3_item.day = r_s2_d - cdsu_pkg::DAY_W'(1);
                    end
                end
                cdsu_pkg::OP_NEXT_MONTH: begin
                    if (r_s2_m == cdsu_pkg::MONTH_DEC) begin
                        n_s3_item.month = cdsu_pkg::MONTH_JAN;
                        n_s3_item.year  = y_ext + cdsu_pkg::YEXT_W'(1);
                    end else begin
                        n_s3_item.month = r_s2_m + cdsu_pkg::MONTH_W'(1);
                    end
                    step_len = cdsu_pkg::month_len(n_s3_item.month, r_s2_leap);
                    if (r_s2_d > step_len) begin
                        n_s3_item.day = step_len;
                    end
                end
                cdsu_pkg::OP_PREV_MONTH: begin
                    if (r_s2_m == cdsu_pkg::MONTH_JAN) begin
                        n_s3_item.month = cdsu_pkg::MONTH_DEC;
                        n_s3_item.year  = y_ext - cdsu_pkg::YEXT_W'(1);
                    end else begin
                        n_s3_item.month = r_s2_m - cdsu_pkg::MONTH_W'(1);
                    end
                    step_len = cdsu_pkg::month_len(n_s3_item.month, r_s2_leap);
                    if (r_s2_d > step_len) begin
                        n_s3_item.day = step_len;
                    end
                end
                cdsu_pkg::OP_ADD_YEARS: begin
                    n_s3_item.year = y_ext + cdsu_pkg::YEXT_W'(r_s2_amt);
                end
                cdsu_pkg::OP_SUB_YEARS: begin
                    // saturate at year zero, which the range check rejects
                    n_s3_item.year = (r_s2_amt >= r_s2_y) ? '0
                                   : cdsu_pkg::YEXT_W'(r_s2_y - r_s2_amt);
                end
                default: begin
                end
            endcase
            if ((n_s3_item.year == '0) || (17'(n_s3_item.year) > YMAX)) begin
                n_s3_item.range_err = 1'b1;
                n_s3_item.year      = y_ext;
                n_s3_item.month     = r_s2_m;
                n_s3_item.day       = r_s2_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_item <= n_s3_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // ---- stages 4..6 ----
    cdsu_cal_back u_cal_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s3_vld),
        .i_item  (r_s3_item),
        .o_vld   (back_vld),
        .o_res   (back_res)
    );

    assign o_done         = back_vld;
    assign o_out_year     = back_res.year;
    assign o_out_month    = back_res.month;
    assign o_out_day      = back_res.day;
    assign o_weekday      = back_res.weekday;
    assign o_leap_flag    = back_res.leap;
    assign o_month_length = back_res.month_length;
    assign o_date_valid   = back_res.date_valid;
    assign o_range_error  = back_res.range_err;

    // a result beat always traces back to an earlier accepted start
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 6))
        else $error("result beat without matching start");

    // range error only ever accompanies a valid input date
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_range_error |-> o_date_valid)
        else $error("range error on invalid date");

    // invalid dates report weekday zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_date_valid |-> o_weekday == '0)
        else $error("weekday set on invalid date");

    // a valid result has a real month, a nonzero year, a weekday below seven and a month length of at least 28
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_date_valid |->
            (o_out_month != '0) && (o_out_month <= cdsu_pkg::MONTH_DEC) &&
            (o_out_year != '0) && (o_weekday <= 3'd6) && (o_month_length >= 5'd28))
        else $error("valid result out of range");

endmodule
